FILE: hw/rtl/trpd_pkg.sv
`default_nettype none

package trpd_pkg;

  // Palette store geometry
  localparam int PALETTE_COUNT = 16;
  localparam int PAL_NUM_W     = 4;
  localparam int SLOT_W        = 4;
  localparam int PAL_ADDR_W    = PAL_NUM_W + SLOT_W;
  localparam int PAL_DEPTH     = 1 << PAL_ADDR_W;
  localparam int COLOR_W       = 16;

  // Pixels per tile row
  localparam int NUM_PIXELS = 8;
  localparam int PIX_IDX_W  = 3;

  // Operation codes
  localparam logic OP_PALETTE_WRITE = 1'b0;
  localparam logic OP_DECODE        = 1'b1;

  // color_mode register: bit positions and full codes
  localparam int CM_PACKED  = 0;
  localparam int CM_SIXTEEN = 1;

  localparam logic [1:0] MODE_PLANAR4  = 2'b00;
  localparam logic [1:0] MODE_PACKED4  = 2'b01;
  localparam logic [1:0] MODE_PLANAR16 = 2'b10;
  localparam logic [1:0] MODE_PACKED16 = 2'b11;

  typedef struct packed {
    logic        operation;
    logic [7:0]  palette_entry;
    logic [11:0] color_rgb444;
    logic [3:0]  palette_select;
    logic [7:0]  plane_byte_0;
    logic [7:0]  plane_byte_1;
    logic [7:0]  plane_byte_2;
    logic [7:0]  plane_byte_3;
    logic        flip_horizontal;
    logic        zero_transparent;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pixel_color_0;
    logic [15:0] pixel_color_1;
    logic [15:0] pixel_color_2;
    logic [15:0] pixel_color_3;
    logic [15:0] pixel_color_4;
    logic [15:0] pixel_color_5;
    logic [15:0] pixel_color_6;
    logic [15:0] pixel_color_7;
    logic [7:0]  opaque_mask;
  } out_item_t;

  // RGB444 -> RGB565: red to 15..12, green to 10..7, blue to 4..1
  function automatic logic [COLOR_W-1:0] rgb444_to_565(input logic [11:0] c);
    return {c[11:8], 1'b0, c[7:4], 2'b00, c[3:0], 1'b0};
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/trpd_in_if.sv
`default_nettype none

interface trpd_in_if import trpd_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/trpd_out_if.sv
`default_nettype none

interface trpd_out_if import trpd_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/tile_row_palette_decoder.sv
// Tile-row palette decoder. A palette write (operation 0) stores one RGB444 color,
// converted to RGB565, into a 256 x 16 palette RAM; it gives no result. A decode
// (operation 1) turns four plane bytes into eight 4-bit indices (planar or packed,
// four or sixteen colors, per color_mode), applies the horizontal flip and looks
// each index up in the selected palette. The palette RAM has a single read port,
// so the eight lookups run one per cycle. A decode occupies the input through
// accept, eight reads, the read latency and the hand-off, longer if the previous
// row still sits unread in the output register. The next item is taken while a
// finished row waits there. Reset clears the palette at once through per-entry
// valid bits; no clearing pass is needed. The user writes color_mode through
// cfg_we/cfg_wdata only while the block is idle; the block does not enforce it.
`default_nettype none

module tile_row_palette_decoder import trpd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_wdata,
  trpd_in_if.sink         in_ch,
  trpd_out_if.source      out_ch
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_HAND  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [1:0]           color_mode_r;
  logic [PIX_IDX_W-1:0] cnt_r;
  logic                 out_valid_r;
  logic                 rd_pend_r;
  logic [PIX_IDX_W-1:0] rd_slot_r;
  logic [PAL_DEPTH-1:0] valid_r;

  logic [SLOT_W-1:0]    idx_r [NUM_PIXELS];
  logic [PAL_NUM_W-1:0] sel_r;
  logic                 sel_ok_r;
  logic [7:0]           mask_r;
  logic [COLOR_W-1:0]   rd_data_r;
  logic                 rd_hit_r;
  logic [COLOR_W-1:0]   col_r [NUM_PIXELS];
  out_item_t            out_r;

  logic [COLOR_W-1:0]   pal_mem [PAL_DEPTH];

  in_item_t             item;
  logic                 in_fire;
  logic                 pal_we;
  logic [PAL_ADDR_W-1:0] pal_waddr;
  logic [COLOR_W-1:0]   pal_wdata;
  logic                 rd_en;
  logic [PAL_ADDR_W-1:0] rd_addr;
  logic                 out_load;
  logic                 out_fire;

  logic [31:0]          planes;
  logic [SLOT_W-1:0]    raw_idx [NUM_PIXELS];
  logic [SLOT_W-1:0]    dec_idx [NUM_PIXELS];
  logic [7:0]           dec_mask;
  logic                 transp;

  assign item    = in_ch.payload;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire = in_ch.valid && in_ch.ready;

  assign pal_we    = in_fire && (item.operation == OP_PALETTE_WRITE) &&
                     ({1'b0, item.palette_entry[7:4]} < (PAL_NUM_W + 1)'(PALETTE_COUNT));
  assign pal_waddr = item.palette_entry;
  assign pal_wdata = rgb444_to_565(item.color_rgb444);

  // Writes only happen in idle and reads only in the read phase, so no forwarding
  assign rd_en   = (state_r == ST_READ);
  assign rd_addr = {sel_r, idx_r[0]};

  assign out_fire = out_valid_r && out_ch.ready;
  assign out_load = (state_r == ST_HAND) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_r;

  // Pixel index extraction
  assign planes = {item.plane_byte_0, item.plane_byte_1, item.plane_byte_2, item.plane_byte_3};

  always_comb begin
    transp = item.zero_transparent | color_mode_r[CM_SIXTEEN];
    for (int p = 0; p < NUM_PIXELS; p++) begin
      unique case (color_mode_r)
        MODE_PACKED16: raw_idx[p] = planes[31 - 4*p -: 4];
        MODE_PACKED4:  raw_idx[p] = {2'b00, planes[31 - 2*p -: 2]};
        MODE_PLANAR16: raw_idx[p] = {planes[7 - p], planes[15 - p],
                                     planes[23 - p], planes[31 - p]};
        MODE_PLANAR4:  raw_idx[p] = {2'b00, planes[23 - p], planes[31 - p]};
      endcase
    end
    for (int p = 0; p < NUM_PIXELS; p++) begin
      dec_idx[p]  = item.flip_horizontal ? raw_idx[NUM_PIXELS-1-p] : raw_idx[p];
      dec_mask[p] = !(transp && (dec_idx[p] == '0));
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire && (item.operation == OP_DECODE)) state_nxt = ST_READ;
      ST_READ:  if (cnt_r == PIX_IDX_W'(NUM_PIXELS - 1)) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_HAND;
      ST_HAND:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      color_mode_r <= MODE_PLANAR4;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      rd_pend_r    <= 1'b0;
      rd_slot_r    <= '0;
      valid_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) color_mode_r <= cfg_wdata;
      if (pal_we) valid_r[pal_waddr] <= 1'b1;
      cnt_r     <= rd_en ? cnt_r + 1'b1 : '0;
      rd_pend_r <= rd_en;
      rd_slot_r <= cnt_r;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_fire) out_valid_r <= 1'b0;
    end
  end

  // Palette RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (pal_we) pal_mem[pal_waddr] <= pal_wdata;
    if (rd_en) rd_data_r <= pal_mem[rd_addr];
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      idx_r    <= dec_idx;
      sel_r    <= item.palette_select;
      sel_ok_r <= ({1'b0, item.palette_select} < (PAL_NUM_W + 1)'(PALETTE_COUNT));
      mask_r   <= dec_mask;
    end else if (rd_en) begin
      // advance the index queue, head feeds the read address
      for (int i = 0; i < NUM_PIXELS - 1; i++) idx_r[i] <= idx_r[i+1];
    end
    if (rd_en) rd_hit_r <= valid_r[rd_addr] && sel_ok_r;
    if (rd_pend_r) col_r[rd_slot_r] <= rd_hit_r ? rd_data_r : '0;
    if (out_load) begin
      out_r.pixel_color_0 <= col_r[0];
      out_r.pixel_color_1 <= col_r[1];
      out_r.pixel_color_2 <= col_r[2];
      out_r.pixel_color_3 <= col_r[3];
      out_r.pixel_color_4 <= col_r[4];
      out_r.pixel_color_5 <= col_r[5];
      out_r.pixel_color_6 <= col_r[6];
      out_r.pixel_color_7 <= col_r[7];
      out_r.opaque_mask   <= mask_r;
    end
  end

endmodule

`default_nettype wire

FILE: tb/tb_tile_row_palette_decoder.sv
`default_nettype none

module tb_tile_row_palette_decoder import trpd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  class tile_row_checker;
    logic [COLOR_W-1:0] palette [PAL_DEPTH];
    logic [1:0]         mode;
    out_item_t          rows_due [$];
    int unsigned        fails;

    function new();
      foreach (palette[i]) palette[i] = '0;
      mode  = MODE_PLANAR4;
      fails = 0;
    endfunction

    function void set_mode(input logic [1:0] m);
      mode = m;
    endfunction

    function void mismatch(input string what, input logic [15:0] want,
                           input logic [15:0] got);
      fails++;
      if (fails <= 10)
        $display("%0t: %s expected %h got %h", $realtime, what, want, got);
    endfunction

    static function logic [7:0][15:0] colors_of(input out_item_t r);
      return {r.pixel_color_7, r.pixel_color_6, r.pixel_color_5, r.pixel_color_4,
              r.pixel_color_3, r.pixel_color_2, r.pixel_color_1, r.pixel_color_0};
    endfunction

    // Index of pixel p counted from the left, before any flip
    function logic [3:0] pixel_code(input logic [3:0][7:0] planes, input int unsigned p);
      logic [3:0]  code;
      int unsigned sh;
      code = '0;
      if (mode[CM_PACKED] && mode[CM_SIXTEEN]) begin
        sh   = (p % 2 == 1) ? 0 : 4;
        code = 4'(planes[(p >> 1) % 4] >> sh);
      end else if (mode[CM_PACKED]) begin
        sh   = 6 - 2 * (p % 4);
        code = {2'b00, 2'(planes[(p >> 2) % 2] >> sh)};
      end else begin
        sh      = 7 - (p % 8);
        code[0] = planes[0][sh];
        code[1] = planes[1][sh];
        if (mode[CM_SIXTEEN]) begin
          code[2] = planes[2][sh];
          code[3] = planes[3][sh];
        end
      end
      return code;
    endfunction

    function void note_transfer(input in_item_t it);
      logic [3:0][7:0]  planes;
      logic [7:0][15:0] colors;
      logic [7:0]       mask;
      logic [3:0]       code;
      logic [15:0]      c;
      bit               clear_zero;
      out_item_t        row;
      if (it.operation == OP_PALETTE_WRITE) begin
        c = {4'h0, it.color_rgb444};
        if (int'(it.palette_entry[7:4]) < PALETTE_COUNT)
          palette[it.palette_entry] = ((c & 16'h0F00) << 4) | ((c & 16'h00F0) << 3)
                                    | ((c & 16'h000F) << 1);
        return;
      end
      planes     = {it.plane_byte_3, it.plane_byte_2, it.plane_byte_1, it.plane_byte_0};
      clear_zero = it.zero_transparent || mode[CM_SIXTEEN];
      mask       = '0;
      for (int p = 0; p < NUM_PIXELS; p++) begin
        code      = pixel_code(planes, it.flip_horizontal ? 7 - p : p);
        colors[p] = (int'(it.palette_select) < PALETTE_COUNT) ?
                    palette[{it.palette_select, code}] : '0;
        mask[p]   = !(clear_zero && code == 4'd0);
      end
      row = {colors[0], colors[1], colors[2], colors[3],
             colors[4], colors[5], colors[6], colors[7], mask};
      rows_due.push_back(row);
    endfunction

    function void check_row(input out_item_t got);
      out_item_t        want;
      logic [7:0][15:0] wc;
      logic [7:0][15:0] gc;
      if (rows_due.size() == 0) begin
        mismatch("row with none pending, mask", 16'h0, {8'h0, got.opaque_mask});
        return;
      end
      want = rows_due.pop_front();
      wc   = colors_of(want);
      gc   = colors_of(got);
      for (int p = 0; p < NUM_PIXELS; p++)
        if (wc[p] !== gc[p]) mismatch($sformatf("pixel_color_%0d", p), wc[p], gc[p]);
      if (want.opaque_mask !== got.opaque_mask)
        mismatch("opaque_mask", {8'h0, want.opaque_mask}, {8'h0, got.opaque_mask});
    endfunction

    function void flag_leftovers();
      if (rows_due.size() != 0)
        mismatch("rows never delivered", 16'h0, 16'(rows_due.size()));
    endfunction
  endclass

  localparam int RANDOM_PER_PHASE = 262;
  localparam int SETTLE_CYCLES    = 24;
  localparam int HOLD_CYCLES      = 400;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int HOLD_PHASE       = 1;
  localparam int STEADY_PHASE     = 3;
  localparam int PAUSE_PHASE      = 4;

  localparam logic [1:0] PHASE_MODES [7] = '{MODE_PLANAR4, MODE_PACKED4, MODE_PLANAR16,
                                             MODE_PACKED16, MODE_PLANAR16, MODE_PACKED4,
                                             MODE_PACKED16};

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_wdata;
  bit         steady;
  bit         hold_req;
  int         quiet_cycles;

  trpd_in_if  in_ch ();
  trpd_out_if out_ch ();

  tile_row_checker chk = new();

  tile_row_palette_decoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.operation        = ($urandom_range(0, 99) < 35) ? OP_PALETTE_WRITE : OP_DECODE;
    it.palette_entry    = 8'($urandom);
    it.color_rgb444     = 12'($urandom);
    it.palette_select   = 4'($urandom);
    it.plane_byte_0     = 8'($urandom);
    it.plane_byte_1     = 8'($urandom);
    it.plane_byte_2     = 8'($urandom);
    it.plane_byte_3     = 8'($urandom);
    it.flip_horizontal  = 1'($urandom);
    it.zero_transparent = 1'($urandom);
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk); while (!in_ch.ready);
    chk.note_transfer(it);
  endtask

  task automatic write_color(input logic [7:0] entry, input logic [11:0] rgb);
    in_item_t it;
    it               = '0;
    it.operation     = OP_PALETTE_WRITE;
    it.palette_entry = entry;
    it.color_rgb444  = rgb;
    send_item(it);
  endtask

  task automatic decode_row(input logic [3:0] sel, input logic [31:0] bytes,
                            input bit flip, input bit ztr);
    in_item_t it;
    it                  = '0;
    it.operation        = OP_DECODE;
    it.palette_select   = sel;
    {it.plane_byte_0, it.plane_byte_1, it.plane_byte_2, it.plane_byte_3} = bytes;
    it.flip_horizontal  = flip;
    it.zero_transparent = ztr;
    send_item(it);
  endtask

  // Drop valid and hold until every pending row has been transferred
  task automatic wait_for_rows();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (chk.rows_due.size() != 0);
  endtask

  task automatic set_color_mode(input logic [1:0] m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    chk.set_mode(m);
  endtask

  // Receiver: random ready pattern, one long hold-off on request
  initial begin
    int unsigned run;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
        run = idle_len();
        if (run != 0) begin
          out_ch.ready <= 1'b0;
          repeat (run) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) chk.check_row(out_ch.payload);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = 2'b00;
    rst_n         = 1'b0;
    steady        = 1'b0;
    hold_req      = 1'b0;
    quiet_cycles  = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < 7; ph++) begin
      set_color_mode(PHASE_MODES[ph]);
      steady = (ph == STEADY_PHASE);

      if (ph == 0) begin
        // Rows read an untouched palette first, then the color extremes land
        decode_row(4'd0, 32'h0000_0000, 1'b0, 1'b0);
        decode_row(4'd0, 32'h0000_0000, 1'b0, 1'b1);
        write_color(8'h00, 12'hFFF);
        write_color(8'h01, 12'hF00);
        write_color(8'h02, 12'h0F0);
        write_color(8'h03, 12'h00F);
        write_color(8'hFF, 12'hFFF);
        write_color(8'hF0, 12'h5A5);
        decode_row(4'd15, 32'hFFFF_FFFF, 1'b1, 1'b0);
        decode_row(4'd15, 32'hFF00_FF00, 1'b0, 1'b1);
      end
      if (ph < 4) begin
        decode_row(4'd0, 32'h1BE4_00FF, 1'b0, 1'b0);
        decode_row(4'd0, 32'h1BE4_00FF, 1'b1, 1'b1);
        decode_row(4'd15, 32'h0000_0000, 1'b0, 1'b0);
      end

      if (ph == HOLD_PHASE) hold_req = 1'b1;
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        if (ph == PAUSE_PHASE && k == RANDOM_PER_PHASE / 2) wait_for_rows();
        send_item(random_item());
      end

      wait_for_rows();
      // let a trailing palette write finish before touching the register
      repeat (SETTLE_CYCLES) @(posedge clk);
    end

    chk.flag_leftovers();
    if (chk.fails == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire

FILE: tile_row_palette_decoder.f
hw/rtl/trpd_pkg.sv
hw/rtl/trpd_in_if.sv
hw/rtl/trpd_out_if.sv
hw/rtl/tile_row_palette_decoder.sv
tb/tb_tile_row_palette_decoder.sv
